[src/ekfcp_pkg.sv]
// ----------------------------------------------------------------------------
// ekfcp_pkg
// Types, fixed-point constants and helper functions shared by the
// covariance prediction block.
// ----------------------------------------------------------------------------
`default_nettype none

package ekfcp_pkg;

  localparam int STATE_DIM    = 7;
  localparam int N_ENTRIES    = STATE_DIM * STATE_DIM;
  localparam int FRAC_BITS    = 24;
  localparam int TRIG_BITS    = 28;
  localparam int CORDIC_ITERS = 24;
  localparam int SERIES_BITS  = 56;
  localparam int DT_SHIFT     = FRAC_BITS - 16;
  localparam int JAC_SHIFT    = TRIG_BITS + 8 + 16 - FRAC_BITS;

  localparam logic signed [31:0] CORDIC_GAIN  = 32'sd163008218;
  localparam logic signed [31:0] PI_T         = 32'sd843314857;
  localparam logic signed [31:0] HALF_PI_T    = 32'sd421657428;
  localparam logic signed [31:0] QUARTER_PI_T = 32'sd210828714;

  localparam logic signed [31:0] VAR_SMALL =
    32'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic signed [31:0] VAR_LARGE =
    32'((64'd9 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic signed [31:0] VAR_HEAD =
    32'(((64'd1 << FRAC_BITS) + 64'd200) / 64'd400);

  localparam logic [3:0] REG_STEP_TIME     = 4'd0;
  localparam logic [3:0] REG_NOISE_POS_X   = 4'd1;
  localparam logic [3:0] REG_NOISE_POS_Y   = 4'd2;
  localparam logic [3:0] REG_NOISE_POS_Z   = 4'd3;
  localparam logic [3:0] REG_NOISE_VEL_X   = 4'd4;
  localparam logic [3:0] REG_NOISE_VEL_Y   = 4'd5;
  localparam logic [3:0] REG_NOISE_VEL_Z   = 4'd6;
  localparam logic [3:0] REG_NOISE_HEADING = 4'd7;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] entry_value;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } trig_t;

  typedef struct packed {
    logic signed [31:0] g36;
    logic signed [31:0] g46;
  } jac_t;

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // atan(2^-i) in Q.28 by its power series, long division done bit by bit
  function automatic logic signed [31:0] atan_entry(int i);
    logic [63:0] acc;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] quo;
    int          s;
    int          d;
    int          b;
    logic        plus;
    if (i == 0) begin
      return QUARTER_PI_T;
    end
    acc  = 64'd0;
    plus = 1'b1;
    d    = 1;
    for (s = i; s < SERIES_BITS; s += 2 * i) begin
      num = (64'd1 << SERIES_BITS) >> s;
      rem = 64'd0;
      quo = 64'd0;
      for (b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= 64'(d)) begin
          rem    = rem - 64'(d);
          quo[b] = 1'b1;
        end
      end
      acc  = plus ? acc + quo : acc - quo;
      plus = !plus;
      d    = d + 2;
    end
    return 32'((acc + (64'd1 << (SERIES_BITS - TRIG_BITS - 1))) >> (SERIES_BITS - TRIG_BITS));
  endfunction

  function automatic logic signed [31:0] cov_reset(int k);
    case (k)
      0, 8, 24, 32: return VAR_SMALL;
      16, 40:       return VAR_LARGE;
      48:           return VAR_HEAD;
      default:      return 32'sd0;
    endcase
  endfunction

endpackage

`default_nettype wire

[src/ekfcp_cell.sv]
// ----------------------------------------------------------------------------
// ekfcp_cell
// One covariance word of the circular chain; takes its neighbour's word
// on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ekfcp_cell #(
  parameter logic signed [31:0] RESET_VALUE = 32'sd0
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               shift,
  input  wire logic signed [31:0] din,
  output logic signed [31:0]      dout
);

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= RESET_VALUE;
    end else if (shift) begin
      dout <= din;
    end
  end

endmodule

`default_nettype wire

[src/ekfcp_cordic.sv]
// ----------------------------------------------------------------------------
// ekfcp_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, giving
// cosine and sine of a Q.28 angle.
// ----------------------------------------------------------------------------
`default_nettype none

module ekfcp_cordic
  import ekfcp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] angle,
  output logic                    done,
  output trig_t                   result
);

  logic               busy;
  logic [4:0]         iter;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [31:0] z;
  logic               neg;
  logic signed [31:0] atan_tab [CORDIC_ITERS];

  for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_atan
    localparam logic signed [31:0] ATAN_G = atan_entry(g);
    assign atan_tab[g] = ATAN_G;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        if (iter == 5'(CORDIC_ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          iter <= iter + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= CORDIC_GAIN;
      y <= 32'sd0;
      if (angle > HALF_PI_T) begin
        z   <= angle - PI_T;
        neg <= 1'b1;
      end else if (angle < -HALF_PI_T) begin
        z   <= angle + PI_T;
        neg <= 1'b1;
      end else begin
        z   <= angle;
        neg <= 1'b0;
      end
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - (y >>> iter);
        y <= y + (x >>> iter);
        z <= z - atan_tab[iter];
      end else begin
        x <= x + (y >>> iter);
        y <= y - (x >>> iter);
        z <= z + atan_tab[iter];
      end
    end
  end

  assign result.cos_v = neg ? -x : x;
  assign result.sin_v = neg ? -y : y;

endmodule

`default_nettype wire

[src/ekfcp_jacobian.sv]
// ----------------------------------------------------------------------------
// ekfcp_jacobian
// Heading terms of the Jacobian: three CORDIC runs, then a short
// multiply sequence on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module ekfcp_jacobian
  import ekfcp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire in_item_t    item,
  input  wire logic [15:0] dt,
  output logic             done,
  output jac_t             terms
);

  typedef enum logic [2:0] {
    J_IDLE = 3'b001,
    J_TRIG = 3'b010,
    J_MUL  = 3'b100
  } j_state_t;

  localparam int SPLIT = 24;
  localparam logic [4:0] LAST_STEP = 5'd24;

  j_state_t           state;
  logic [1:0]         trig_idx;
  logic [4:0]         step;
  logic               cstart;
  logic               cdone;
  trig_t              cres;
  logic signed [31:0] cangle;
  in_item_t           hold;
  logic signed [31:0] cph, sph, cth, sth, cps, sps;
  logic signed [31:0] t1, t2, r0, r1, r2;
  logic signed [63:0] p, hp, acc;
  logic signed [31:0] opa, opb;
  logic signed [63:0] m;
  logic signed [31:0] acc_hi, acc_lo, dt_op, ax, ay, az;

  ekfcp_cordic u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cstart),
    .angle  (cangle),
    .done   (cdone),
    .result (cres)
  );

  always_comb begin
    unique case (trig_idx)
      2'd0:    cangle = {hold.roll[15], hold.roll, 15'b0};
      2'd1:    cangle = {hold.pitch[15], hold.pitch, 15'b0};
      default: cangle = {hold.yaw[15], hold.yaw, 15'b0};
    endcase
  end

  assign m      = p >>> TRIG_BITS;
  assign acc_hi = 32'(acc >>> SPLIT);
  assign acc_lo = {8'b0, acc[SPLIT-1:0]};
  assign dt_op  = {16'b0, dt};
  assign ax     = 32'(hold.accel_x);
  assign ay     = 32'(hold.accel_y);
  assign az     = 32'(hold.accel_z);

  always_comb begin
    unique case (step)
      5'd0:           begin opa = sph;    opb = sth;   end
      5'd1:           begin opa = cph;    opb = sth;   end
      5'd2:           begin opa = cth;    opb = sps;   end
      5'd3:           begin opa = t1;     opb = sps;   end
      5'd4, 5'd13:    begin opa = cth;    opb = cps;   end
      5'd5:           begin opa = t2;     opb = sps;   end
      5'd6:           begin opa = sph;    opb = cps;   end
      5'd7, 5'd18:    begin opa = r0;     opb = ax;    end
      5'd8, 5'd19:    begin opa = r1;     opb = ay;    end
      5'd9, 5'd20:    begin opa = r2;     opb = az;    end
      5'd11, 5'd22:   begin opa = acc_hi; opb = dt_op; end
      5'd12, 5'd23:   begin opa = acc_lo; opb = dt_op; end
      5'd14:          begin opa = t1;     opb = cps;   end
      5'd15:          begin opa = cph;    opb = sps;   end
      5'd16:          begin opa = t2;     opb = cps;   end
      5'd17:          begin opa = sph;    opb = sps;   end
      default:        begin opa = 32'sd0; opb = 32'sd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= J_IDLE;
      trig_idx <= '0;
      step     <= '0;
      cstart   <= 1'b0;
      done     <= 1'b0;
    end else begin
      cstart <= 1'b0;
      done   <= 1'b0;
      unique case (state)
        J_IDLE: begin
          if (start) begin
            trig_idx <= '0;
            cstart   <= 1'b1;
            state    <= J_TRIG;
          end
        end
        J_TRIG: begin
          if (cdone) begin
            if (trig_idx == 2'd2) begin
              step  <= '0;
              state <= J_MUL;
            end else begin
              trig_idx <= trig_idx + 2'd1;
              cstart   <= 1'b1;
            end
          end
        end
        J_MUL: begin
          if (step == LAST_STEP) begin
            done  <= 1'b1;
            state <= J_IDLE;
          end else begin
            step <= step + 5'd1;
          end
        end
        default: state <= J_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == J_IDLE && start) begin
      hold <= item;
    end
    if (state == J_TRIG && cdone) begin
      unique case (trig_idx)
        2'd0:    begin cph <= cres.cos_v; sph <= cres.sin_v; end
        2'd1:    begin cth <= cres.cos_v; sth <= cres.sin_v; end
        default: begin cps <= cres.cos_v; sps <= cres.sin_v; end
      endcase
    end
    if (state == J_MUL) begin
      p <= opa * opb;
      unique case (step)
        5'd1:         t1 <= 32'(m);
        5'd2:         t2 <= 32'(m);
        5'd3:         r0 <= 32'(-m);
        5'd4:         r1 <= 32'(-m);
        5'd5:         r1 <= r1 - 32'(m);
        5'd6:         r2 <= 32'(-m);
        5'd7:         r2 <= r2 + 32'(m);
        5'd8, 5'd19:  acc <= p;
        5'd9, 5'd10,
        5'd20, 5'd21: acc <= acc + p;
        5'd12, 5'd23: hp <= p;
        5'd13:        terms.g36 <= sat32(((hp <<< SPLIT) + p) >>> JAC_SHIFT);
        5'd14:        r0 <= 32'(m);
        5'd15:        r1 <= 32'(m);
        5'd16:        r1 <= r1 - 32'(m);
        5'd17:        r2 <= 32'(m);
        5'd18:        r2 <= r2 + 32'(m);
        5'd24:        terms.g46 <= sat32(((hp <<< SPLIT) + p) >>> JAC_SHIFT);
        default:      ;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/ekf_covariance_predict.sv]
// ----------------------------------------------------------------------------
// ekf_covariance_predict
// Covariance prediction step of a seven-state extended Kalman filter.
//
// Input channel (in_valid / in_stall / in_data): roll, pitch, yaw in Q2.13
// radians and body accelerations in Q8.8. One transaction starts a run; the
// input stalls until the run has finished.
// Output channel (out_valid / out_stall / out_data): the 49 new covariance
// entries, row-major, each with row and column, last set on entry (6,6).
// Configuration: cfg_write / cfg_index / cfg_data write dt and the seven
// process noise values; write only while no run is in progress.
// Sequence: trig and Jacobian work (three CORDIC runs on one iterative
// unit, then 25 steps on a shared multiplier), then two passes over the
// 49-cell covariance chain, one entry at a time through a single multiplier.
// A stall on the output holds the second pass.
// Reset restores the initial variances and the default register values.
// ----------------------------------------------------------------------------
`default_nettype none

module ekf_covariance_predict
  import ekfcp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [30:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data
);

  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_JAC   = 4'b0010,
    T_PASS1 = 4'b0100,
    T_PASS2 = 4'b1000
  } t_state_t;

  localparam logic [2:0] LAST_IDX = 3'(STATE_DIM - 1);

  t_state_t           state;
  logic [15:0]        step_time;
  logic [30:0]        noise [STATE_DIM];
  logic               in_accept;
  logic               jac_done;
  jac_t               jac;
  logic signed [31:0] chain [N_ENTRIES];
  logic               shift;
  logic               phase;
  logic [2:0]         r;
  logic [2:0]         c;
  logic [2:0]         sel;
  logic               pass1;
  logic               near;
  logic               use_p;
  logic               use_q;
  logic signed [31:0] coef;
  logic signed [31:0] tap;
  logic signed [31:0] dt_term;
  logic signed [63:0] prod;
  logic signed [63:0] sum;
  logic signed [31:0] s1;
  logic signed [31:0] new_value;
  logic               slot_free;

  assign in_stall  = (state != T_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= 16'd655;
      noise[0]  <= 31'd42;
      noise[1]  <= 31'd42;
      noise[2]  <= 31'd42;
      noise[3]  <= 31'd671;
      noise[4]  <= 31'd671;
      noise[5]  <= 31'd168;
      noise[6]  <= 31'd107;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STEP_TIME:     step_time <= cfg_data[15:0];
        REG_NOISE_POS_X:   noise[0]  <= cfg_data;
        REG_NOISE_POS_Y:   noise[1]  <= cfg_data;
        REG_NOISE_POS_Z:   noise[2]  <= cfg_data;
        REG_NOISE_VEL_X:   noise[3]  <= cfg_data;
        REG_NOISE_VEL_Y:   noise[4]  <= cfg_data;
        REG_NOISE_VEL_Z:   noise[5]  <= cfg_data;
        REG_NOISE_HEADING: noise[6]  <= cfg_data;
        default:           ;
      endcase
    end
  end

  ekfcp_jacobian u_jacobian (
    .clk   (clk),
    .rst   (rst),
    .start (in_accept),
    .item  (in_data),
    .dt    (step_time),
    .done  (jac_done),
    .terms (jac)
  );

  for (genvar k = 0; k < N_ENTRIES; k++) begin : g_cell
    logic signed [31:0] din;
    if (k == N_ENTRIES - 1) begin : g_tail
      assign din = new_value;
    end else begin : g_link
      assign din = chain[k+1];
    end
    ekfcp_cell #(
      .RESET_VALUE (cov_reset(k))
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .din   (din),
      .dout  (chain[k])
    );
  end

  assign pass1   = (state == T_PASS1);
  assign sel     = pass1 ? r : c;
  assign near    = (sel == 3'd4);
  assign dt_term = 32'(step_time) <<< DT_SHIFT;

  always_comb begin
    use_p = 1'b1;
    priority if (sel < 3'd3) begin
      coef = dt_term;
    end else if (sel == 3'd3) begin
      coef = jac.g36;
    end else if (sel == 3'd4) begin
      coef = jac.g46;
    end else begin
      coef  = 32'sd0;
      use_p = 1'b0;
    end
    if (pass1) begin
      tap = near ? chain[2 * STATE_DIM] : chain[3 * STATE_DIM];
    end else begin
      tap = near ? chain[2] : chain[3];
    end
  end

  assign slot_free = !out_valid || !out_stall;
  assign shift     = phase && (pass1 || (state == T_PASS2 && slot_free));

  assign sum = 64'(chain[0]) + (use_q ? (prod >>> FRAC_BITS) : 64'sd0);
  assign s1  = sat32(sum);
  assign new_value = (!pass1 && r == c) ?
                     sat32(64'(s1) + $signed({33'b0, noise[r]})) : s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      phase     <= 1'b0;
      r         <= '0;
      c         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == T_PASS2 && phase && slot_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (in_accept) begin
            state <= T_JAC;
          end
        end
        T_JAC: begin
          if (jac_done) begin
            phase <= 1'b0;
            r     <= '0;
            c     <= '0;
            state <= T_PASS1;
          end
        end
        T_PASS1, T_PASS2: begin
          if (!phase) begin
            phase <= 1'b1;
          end else if (shift) begin
            phase <= 1'b0;
            if (c == LAST_IDX) begin
              c <= '0;
              if (r == LAST_IDX) begin
                r     <= '0;
                state <= pass1 ? T_PASS2 : T_IDLE;
              end else begin
                r <= r + 3'd1;
              end
            end else begin
              c <= c + 3'd1;
            end
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!phase) begin
      prod  <= coef * tap;
      use_q <= use_p;
    end
    if (state == T_PASS2 && phase && slot_free) begin
      out_data.row         <= r;
      out_data.col         <= c;
      out_data.entry_value <= new_value;
      out_data.last        <= (r == LAST_IDX) && (c == LAST_IDX);
    end
  end

  a_last_flag : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last == (out_data.row == LAST_IDX && out_data.col == LAST_IDX)))
    else $error("last flag does not match entry position");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall)
    else $error("input not stalled after a transaction");

  a_index_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.row <= LAST_IDX && out_data.col <= LAST_IDX))
    else $error("entry index out of range");

  a_emit_in_pass2 : assert property (@(posedge clk) disable iff (rst)
    (!out_valid && $past(!out_valid) && state != T_PASS2) |=> !out_valid)
    else $error("entry emitted outside the output pass");

endmodule

`default_nettype wire

[tb/tb_ekf_covariance_predict.sv]
// ----------------------------------------------------------------------------
// tb_ekf_covariance_predict
// Self-checking bench for the covariance prediction block. A predictor
// mirrors the CORDIC, Jacobian and G*P*G^T + Q arithmetic; every transaction
// on the output is compared with the oldest predicted entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_ekf_covariance_predict;
  import ekfcp_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [3:0]  cfg_index;
  logic [30:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;

  ekf_covariance_predict dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  localparam longint CYCLE_LIMIT = 2000000;

  out_item_t   entry_queue[$];
  int          error_count;
  longint      cycle_count;
  int          stall_mode;
  logic [15:0] dt_reg;
  logic [30:0] noise_reg[STATE_DIM];
  longint      cov_model[STATE_DIM][STATE_DIM];
  longint      atan_tab[CORDIC_ITERS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint asr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_series(int i);
    longint acc;
    longint t;
    int     s;
    int     d;
    bit     plus;
    acc  = 0;
    d    = 1;
    plus = 1'b1;
    if (i == 0) return QUARTER_PI_T;
    for (s = i; s < SERIES_BITS; s += 2 * i) begin
      t    = (64'sd1 << (SERIES_BITS - s)) / d;
      acc  = plus ? acc + t : acc - t;
      plus = !plus;
      d   += 2;
    end
    return (acc + (64'sd1 << (SERIES_BITS - TRIG_BITS - 1))) >>> (SERIES_BITS - TRIG_BITS);
  endfunction

  task automatic rotate(input longint ang, output longint c, output longint s);
    longint x;
    longint y;
    longint z;
    longint nx;
    bit     flip;
    x    = CORDIC_GAIN;
    y    = 0;
    z    = ang;
    flip = 1'b0;
    if (z > HALF_PI_T) begin
      z -= PI_T;
      flip = 1'b1;
    end else if (z < -HALF_PI_T) begin
      z += PI_T;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (z >= 0) begin
        nx = x - asr_floor(y, i);
        y  = y + asr_floor(x, i);
        z -= atan_tab[i];
      end else begin
        nx = x + asr_floor(y, i);
        y  = y - asr_floor(x, i);
        z += atan_tab[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint tmul(longint a, longint b);
    return asr_floor(a * b, TRIG_BITS);
  endfunction

  function automatic longint fmul(longint a, longint b);
    return asr_floor(a * b, FRAC_BITS);
  endfunction

  task automatic reset_model();
    dt_reg = 16'd655;
    noise_reg[0] = 31'd42;
    noise_reg[1] = 31'd42;
    noise_reg[2] = 31'd42;
    noise_reg[3] = 31'd671;
    noise_reg[4] = 31'd671;
    noise_reg[5] = 31'd168;
    noise_reg[6] = 31'd107;
    for (int i = 0; i < STATE_DIM; i++)
      for (int j = 0; j < STATE_DIM; j++)
        cov_model[i][j] = cov_reset(i * STATE_DIM + j);
    for (int i = 0; i < CORDIC_ITERS; i++) atan_tab[i] = atan_series(i);
  endtask

  task automatic predict_covariance(input in_item_t it);
    longint g[STATE_DIM][STATE_DIM];
    longint gp[STATE_DIM][STATE_DIM];
    longint cr, sr, cp, sp, cy, sy, ax, ay, az, dt, r0, r1, r2, acc;
    out_item_t e;
    rotate(longint'(it.roll) * 32768, cr, sr);
    rotate(longint'(it.pitch) * 32768, cp, sp);
    rotate(longint'(it.yaw) * 32768, cy, sy);
    ax = it.accel_x;
    ay = it.accel_y;
    az = it.accel_z;
    dt = dt_reg;
    for (int i = 0; i < STATE_DIM; i++)
      for (int j = 0; j < STATE_DIM; j++)
        g[i][j] = (i == j) ? (64'sd1 << FRAC_BITS) : 0;
    g[0][3] = dt << DT_SHIFT;
    g[1][4] = dt << DT_SHIFT;
    g[2][5] = dt << DT_SHIFT;
    r0 = -tmul(cp, sy);
    r1 = -tmul(tmul(sr, sp), sy) - tmul(cp, cy);
    r2 = -tmul(tmul(cr, sp), sy) + tmul(sr, cy);
    acc = r0 * ax + r1 * ay + r2 * az;
    g[3][6] = clamp32(asr_floor(acc * dt, JAC_SHIFT));
    r0 = tmul(cp, cy);
    r1 = tmul(tmul(sr, sp), cy) - tmul(cr, sy);
    r2 = tmul(tmul(cr, sp), cy) + tmul(sr, sy);
    acc = r0 * ax + r1 * ay + r2 * az;
    g[4][6] = clamp32(asr_floor(acc * dt, JAC_SHIFT));
    for (int i = 0; i < STATE_DIM; i++)
      for (int j = 0; j < STATE_DIM; j++) begin
        acc = 0;
        for (int k = 0; k < STATE_DIM; k++) acc += fmul(g[i][k], cov_model[k][j]);
        gp[i][j] = clamp32(acc);
      end
    for (int i = 0; i < STATE_DIM; i++)
      for (int j = 0; j < STATE_DIM; j++) begin
        acc = 0;
        for (int k = 0; k < STATE_DIM; k++) acc += fmul(gp[i][k], g[j][k]);
        acc = clamp32(acc);
        if (i == j) acc = clamp32(acc + longint'(noise_reg[i]));
        cov_model[i][j] = acc;
        e.row         = 3'(i);
        e.col         = 3'(j);
        e.entry_value = 32'(acc);
        e.last        = (i == STATE_DIM - 1) && (j == STATE_DIM - 1);
        entry_queue.push_back(e);
      end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ekf_covariance_predict test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (entry_queue.size() == 0) begin
        report_mismatch("unexpected entry", out_data.entry_value, 0);
      end else begin
        want = entry_queue.pop_front();
        if (out_data.row !== want.row) report_mismatch("row", out_data.row, want.row);
        if (out_data.col !== want.col) report_mismatch("col", out_data.col, want.col);
        if (out_data.entry_value !== want.entry_value)
          report_mismatch("entry_value", out_data.entry_value, want.entry_value);
        if (out_data.last !== want.last) report_mismatch("last", out_data.last, want.last);
      end
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
  end

  int burst_left;

  task automatic send_item(input in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 6);
      repeat ($urandom_range(0, 4)) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_covariance(it);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (entry_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [30:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_STEP_TIME) dt_reg = val[15:0];
    else if (idx <= REG_NOISE_HEADING) noise_reg[idx - 1] = val;
    @(posedge clk);
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    it = {$urandom, $urandom, $urandom};
    if ($urandom_range(0, 3) == 0) begin
      it.accel_x = $signed(16'($urandom_range(0, 1024))) - 16'sd512;
      it.accel_y = $signed(16'($urandom_range(0, 1024))) - 16'sd512;
      it.accel_z = $signed(16'($urandom_range(0, 1024))) - 16'sd512;
    end
    return it;
  endfunction

  task automatic test_extremes();
    logic signed [15:0] v[4] = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1};
    in_item_t it;
    for (int k = 0; k < 8; k++) begin
      it = '{v[k % 4], v[(k + 1) % 4], v[(k + 2) % 4], v[(k + 3) % 4], v[k % 4],
             v[(k + 1) % 4]};
      send_item(it);
    end
    // angles across the fold boundaries at +-pi/2
    send_item('{16'sd12868, -16'sd12868, 16'sd12869, 16'sd2560, -16'sd256, 16'sd2509});
    send_item('{-16'sd12869, 16'sd12867, -16'sd25736, 16'sd0, 16'sd0, 16'sd0});
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(REG_STEP_TIME, 31'h7fffffff);
    for (int r = 1; r <= 7; r++) write_reg(4'(r), 31'h7fffffff);
    for (int k = 0; k < 4; k++) send_item(rand_item());
    drain();
    write_reg(REG_STEP_TIME, 31'd0);
    for (int r = 1; r <= 7; r++) write_reg(4'(r), 31'd0);
    write_reg(4'd9, 31'd12345);
    for (int k = 0; k < 3; k++) send_item(rand_item());
    drain();
    write_reg(REG_STEP_TIME, 31'd1000);
    for (int r = 1; r <= 7; r++) write_reg(4'(r), 31'($urandom_range(0, 5000)));
    send_item(rand_item());
    drain();
  endtask

  task automatic test_random();
    for (int k = 0; k < 210; k++) begin
      if (k % 50 == 49) begin
        drain();
        write_reg(REG_STEP_TIME, 31'($urandom_range(0, 4000)));
        for (int r = 1; r <= 7; r++) write_reg(4'(r), 31'($urandom_range(0, 20000)));
      end
      send_item(rand_item());
    end
  endtask

  initial begin
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    stall_mode  = 0;
    burst_left  = 0;
    error_count = 0;
    cycle_count = 0;
    reset_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_config_extremes();
    test_random();
    while (entry_queue.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (error_count == 0 && entry_queue.size() == 0) begin
      $display("ekf_covariance_predict test passed");
    end else begin
      $display("ekf_covariance_predict test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
